// File: rtl/pif_pkg.sv
// Package for the pipelined instruction fetch block.
// Holds opcode and status codes, the request/result structs and the length table.
// No dependencies.
package pif_pkg;

  // Stream widths, padded to whole bytes
  localparam int unsigned S_DATA_W = 128;
  localparam int unsigned M_DATA_W = 120;

  // Opcodes
  localparam logic [3:0] OP_HALT  = 4'h0;
  localparam logic [3:0] OP_NOP   = 4'h1;
  localparam logic [3:0] OP_RRMOV = 4'h2;
  localparam logic [3:0] OP_IRMOV = 4'h3;
  localparam logic [3:0] OP_RMMOV = 4'h4;
  localparam logic [3:0] OP_MRMOV = 4'h5;
  localparam logic [3:0] OP_OPL   = 4'h6;
  localparam logic [3:0] OP_JXX   = 4'h7;
  localparam logic [3:0] OP_CALL  = 4'h8;
  localparam logic [3:0] OP_RET   = 4'h9;
  localparam logic [3:0] OP_PUSH  = 4'hA;
  localparam logic [3:0] OP_POP   = 4'hB;
  localparam logic [3:0] OP_DUMP  = 4'hC;

  // Status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  // Register field constants
  localparam logic [3:0] REG_NONE = 4'hF;
  localparam logic [3:0] IRMOV_RA = 4'h8;
  localparam logic [3:0] STACK_RB = 4'hF;

  // Instruction lengths
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_5   = 3'd5;
  localparam logic [2:0] LEN_6   = 3'd6;

  typedef struct packed {
    logic [3:0]  mem_stage_icode;
    logic        mem_stage_cond;
    logic [31:0] mem_stage_vala;
    logic [3:0]  wb_stage_icode;
    logic [31:0] wb_stage_valm;
    logic [7:0]  inst_byte0;
    logic [7:0]  inst_byte1;
    logic [7:0]  inst_byte2;
    logic [7:0]  inst_byte3;
    logic [7:0]  inst_byte4;
    logic [7:0]  inst_byte5;
    logic [5:0]  byte_fault_mask;
  } req_t;

  typedef struct packed {
    logic [31:0] fetch_pc;
    logic [1:0]  status;
    logic [3:0]  instr_code;
    logic [3:0]  instr_func;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [31:0] const_val;
    logic [31:0] next_pc;
  } res_t;

  // Length by opcode; LEN_BAD marks an undefined opcode
  function automatic logic [2:0] op_len(input logic [3:0] icode);
    logic [2:0] len;
    case (icode)
      OP_HALT, OP_NOP, OP_RET:           len = LEN_1;
      OP_RRMOV, OP_OPL, OP_PUSH, OP_POP: len = LEN_2;
      OP_JXX, OP_CALL, OP_DUMP:          len = LEN_5;
      OP_IRMOV, OP_RMMOV, OP_MRMOV:      len = LEN_6;
      default:                           len = LEN_BAD;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/pif_decode.sv
// Fetch address selection and instruction field split for one request.
// Pure combinational logic between the input and result registers.
// Depends on pif_pkg.
module pif_decode (
  input  pif_pkg::req_t req,
  input  logic [31:0]   pred_pc,
  output pif_pkg::res_t res
);

  logic [31:0] pc;
  logic        op_fault;
  logic [3:0]  icode;
  logic [3:0]  ifun;
  logic [2:0]  len_raw;
  logic        valid;
  logic [2:0]  len;
  logic        has_reg;
  logic        has_c;
  logic        reg_fault;
  logic [5:0]  c_need;
  logic        c_fault;
  logic        adr;
  logic [31:0] c_word;

  // Pick fetch address: mispredicted jump, then return, then prediction
  always_comb begin
    if (req.mem_stage_icode == pif_pkg::OP_JXX && !req.mem_stage_cond) begin
      pc = req.mem_stage_vala;
    end else if (req.wb_stage_icode == pif_pkg::OP_RET) begin
      pc = req.wb_stage_valm;
    end else begin
      pc = pred_pc;
    end
  end

  // Opcode and length
  always_comb begin
    op_fault = req.byte_fault_mask[0];
    icode    = op_fault ? pif_pkg::OP_NOP : req.inst_byte0[7:4];
    ifun     = op_fault ? 4'h0 : req.inst_byte0[3:0];
    len_raw  = pif_pkg::op_len(icode);
    valid    = (len_raw != pif_pkg::LEN_BAD);
    len      = valid ? len_raw : pif_pkg::LEN_1;
    has_reg  = (len == pif_pkg::LEN_2) || (len == pif_pkg::LEN_6);
    has_c    = (len == pif_pkg::LEN_5) || (len == pif_pkg::LEN_6);
  end

  // Fault checks on the bytes the instruction actually uses
  always_comb begin
    reg_fault = !op_fault && has_reg && req.byte_fault_mask[1];
    c_need    = has_reg ? 6'b111100 : 6'b011110;
    c_fault   = !op_fault && !reg_fault && has_c && ((req.byte_fault_mask & c_need) != 6'd0);
    adr       = op_fault || reg_fault || c_fault;
    c_word    = has_reg ? {req.inst_byte5, req.inst_byte4, req.inst_byte3, req.inst_byte2}
                        : {req.inst_byte4, req.inst_byte3, req.inst_byte2, req.inst_byte1};
  end

  // Assemble result
  always_comb begin
    res.fetch_pc   = pc;
    res.instr_code = icode;
    res.instr_func = ifun;
    res.reg_a      = pif_pkg::REG_NONE;
    res.reg_b      = pif_pkg::REG_NONE;
    if (has_reg && !op_fault && !reg_fault) begin
      res.reg_a = (icode == pif_pkg::OP_IRMOV) ? pif_pkg::IRMOV_RA : req.inst_byte1[7:4];
      res.reg_b = (icode == pif_pkg::OP_PUSH || icode == pif_pkg::OP_POP)
                  ? pif_pkg::STACK_RB : req.inst_byte1[3:0];
    end
    res.const_val = (has_c && !adr) ? c_word : 32'd0;
    if (adr) begin
      res.status = pif_pkg::ST_ADR;
    end else if (!valid) begin
      res.status = pif_pkg::ST_INS;
    end else if (icode == pif_pkg::OP_HALT) begin
      res.status = pif_pkg::ST_HLT;
    end else begin
      res.status = pif_pkg::ST_OK;
    end
    res.next_pc = pc + {29'd0, len};
  end

endmodule

// File: rtl/pipelined_instruction_fetch.sv
// Top level of the pipelined instruction fetch block: input register, decode,
// result register and the predicted PC. Depends on pif_pkg and pif_decode.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  s_tdata[126:0] fetch request (stage state, bytes, faults)
//  m_*      out  m_tvalid/m_tready  m_tdata[113:0] decoded instruction and next PC
//
// A request passes the input register, then the result register; one request is taken every
// cycle while the result side keeps up. The rate is set by the single decode
// pass between the input and result registers, which also updates pred_pc.
// rst clears both valid flags and pred_pc to zero.
// A stalled result holds; the input register still refills while it is empty, or while the
// result register is free or being drained in the same cycle.
module pipelined_instruction_fetch (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // mem_stage_icode[3:0], mem_stage_cond[4], mem_stage_vala[36:5],
  // wb_stage_icode[40:37], wb_stage_valm[72:41], inst_byte0[80:73],
  // inst_byte1[88:81], inst_byte2[96:89], inst_byte3[104:97],
  // inst_byte4[112:105], inst_byte5[120:113], byte_fault_mask[126:121], zero pad
  input  logic [pif_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // fetch_pc[31:0], status[33:32], instr_code[37:34], instr_func[41:38],
  // reg_a[45:42], reg_b[49:46], const_val[81:50], next_pc[113:82], zero pad
  output logic [pif_pkg::M_DATA_W-1:0]  m_tdata
);

  pif_pkg::req_t req_in;
  pif_pkg::req_t req_reg;
  logic          req_valid;
  pif_pkg::res_t res_comb;
  pif_pkg::res_t res_reg;
  logic          res_valid;
  logic [31:0]   pred_pc;
  logic          advance;

  // Unpack request
  always_comb begin
    req_in.mem_stage_icode = s_tdata[3:0];
    req_in.mem_stage_cond  = s_tdata[4];
    req_in.mem_stage_vala  = s_tdata[36:5];
    req_in.wb_stage_icode  = s_tdata[40:37];
    req_in.wb_stage_valm   = s_tdata[72:41];
    req_in.inst_byte0      = s_tdata[80:73];
    req_in.inst_byte1      = s_tdata[88:81];
    req_in.inst_byte2      = s_tdata[96:89];
    req_in.inst_byte3      = s_tdata[104:97];
    req_in.inst_byte4      = s_tdata[112:105];
    req_in.inst_byte5      = s_tdata[120:113];
    req_in.byte_fault_mask = s_tdata[126:121];
  end

  // Handshake: move the held request on when the result slot frees up
  assign advance  = req_valid && (!res_valid || m_tready);
  assign s_tready = !req_valid || advance;

  pif_decode u_decode (
    .req     (req_reg),
    .pred_pc (pred_pc),
    .res     (res_comb)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      req_reg <= req_in;
    end
  end

  // Result register and prediction
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      pred_pc   <= 32'd0;
    end else begin
      if (advance) begin
        res_valid <= 1'b1;
        pred_pc   <= res_comb.next_pc;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
    if (advance) begin
      res_reg <= res_comb;
    end
  end

  // Pack result
  assign m_tvalid = res_valid;
  assign m_tdata  = {6'd0, res_reg.next_pc, res_reg.const_val, res_reg.reg_b, res_reg.reg_a,
                     res_reg.instr_func, res_reg.instr_code, res_reg.status, res_reg.fetch_pc};

endmodule

// File: rtl/pif_checker.sv
// Port-level checker for the pipelined instruction fetch block, bound to the top.
// Depends on pif_pkg and on the port layout of pipelined_instruction_fetch.
module pif_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [pif_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [pif_pkg::M_DATA_W-1:0] m_tdata
);

  logic [31:0] fetch_pc;
  logic [1:0]  status;
  logic [3:0]  instr_code;
  logic [31:0] next_pc;
  logic [31:0] len;
  logic        in_req;

  assign fetch_pc   = m_tdata[31:0];
  assign status     = m_tdata[33:32];
  assign instr_code = m_tdata[37:34];
  assign next_pc    = m_tdata[113:82];
  assign len        = next_pc - fetch_pc;
  assign in_req     = s_tvalid && s_tready && (s_tdata[127] == 1'b0);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Nothing shows right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Length is one of the legal sizes
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (len == 32'd1 || len == 32'd2 || len == 32'd5 || len == 32'd6))
    else $error("illegal instruction length");

  // Halt status only for the halt opcode; ok status only for defined opcodes
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (status != pif_pkg::ST_HLT || instr_code == pif_pkg::OP_HALT) &&
                 (status != pif_pkg::ST_OK || instr_code <= pif_pkg::OP_DUMP))
    else $error("status does not match opcode");

  // A request taken while no result is shown must give a valid result via the input and result registers
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_req && !m_tvalid |=> ##1 m_tvalid)
    else $error("result missing after request");

endmodule

bind pipelined_instruction_fetch pif_checker u_pif_checker (.*);
